// File: sv/mbe_pkg.sv
// Shared constants, types and state encodings for the escape-time block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mbe_pkg;

  localparam int unsigned WIDTH      = 640;
  localparam int unsigned HEIGHT     = 480;
  localparam int unsigned FRAC_BITS  = 60;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned STEP_W     = 63;
  localparam int unsigned PIX_W      = 19;
  localparam int unsigned OFF_W      = 21;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PROD_W     = OFF_W + DATA_W;
  localparam int unsigned MAG_W      = 2 * DATA_W;
  localparam int unsigned STEP_SPLIT = 32;
  localparam int unsigned PART_W     = OFF_W + STEP_SPLIT + 1;

  localparam int unsigned DIV_SHIFT  = 32;
  localparam int unsigned QP_W       = PIX_W + DIV_SHIFT + 1;
  localparam logic [63:0] DIV_RECIP  = ((64'd1 << DIV_SHIFT) + 64'(WIDTH) - 64'd1) / 64'(WIDTH);

  localparam logic [DATA_W:0] ESC_LIMIT = 65'd4 << FRAC_BITS;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     inf;
  } cpoint_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_COL, F_MUL_RE, F_ADD_RE, F_MUL_IM, F_ADD_IM, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_TOP, B_ISSUE_II, B_ISSUE_RI, B_GET_II, B_TEST, B_UPDATE, B_DONE
  } back_state_e;

endpackage

`default_nettype wire

// File: sv/mbe_mul.sv
// Two-stage 64x64 magnitude multiplier built from four 32x32 partial products.
// Depends on mbe_pkg.
`default_nettype none

module mbe_mul (
  input  wire logic                             clk_i,
  input  wire logic signed [mbe_pkg::DATA_W-1:0] a_i,
  input  wire logic signed [mbe_pkg::DATA_W-1:0] b_i,
  output logic             [mbe_pkg::MAG_W-1:0]  mag_o,
  output logic                                  neg_o
);
  import mbe_pkg::*;

  logic [DATA_W-1:0] ua, ub;
  logic [63:0]       p00_q, p01_q, p10_q, p11_q;
  logic              neg_a_q;
  logic [MAG_W-1:0]  mag_q;
  logic              neg_q;

  assign ua = a_i[DATA_W-1] ? (64'd0 - a_i) : a_i;
  assign ub = b_i[DATA_W-1] ? (64'd0 - b_i) : b_i;

  always_ff @(posedge clk_i) begin
    p00_q   <= 64'(ua[31:0])  * 64'(ub[31:0]);
    p01_q   <= 64'(ua[31:0])  * 64'(ub[63:32]);
    p10_q   <= 64'(ua[63:32]) * 64'(ub[31:0]);
    p11_q   <= 64'(ua[63:32]) * 64'(ub[63:32]);
    neg_a_q <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
    mag_q   <= {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
             + {p11_q, 64'd0};
    neg_q   <= neg_a_q;
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

// File: sv/mbe_front.sv
// Front end: accepts a pixel index, splits it into row and column and forms c.
// Depends on mbe_pkg; feeds mbe_queue.
`default_nettype none

module mbe_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  output logic                                   full_o,
  input  wire logic        [mbe_pkg::PIX_W-1:0]  pixel_index_i,
  input  wire logic signed [mbe_pkg::DATA_W-1:0] center_x_i,
  input  wire logic signed [mbe_pkg::DATA_W-1:0] center_y_i,
  input  wire logic        [mbe_pkg::STEP_W-1:0] pixel_step_i,
  output logic                                   q_push_o,
  input  wire logic                              q_full_i,
  output mbe_pkg::cpoint_t                       q_data_o
);
  import mbe_pkg::*;

  front_state_e state_q, state_d;

  logic        [PIX_W-1:0]  idx_q, row_q, col_q;
  logic signed [PART_W-1:0] plo_q, phi_q;
  cpoint_t                  c_q;

  logic        [QP_W-1:0]   quot_prod;
  logic signed [OFF_W-1:0]  off;
  logic signed [PART_W-1:0] plo, phi;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_ok;
  logic signed [DATA_W-1:0] center;
  logic        [DATA_W:0]   sum;
  logic                     add_ok;

  assign quot_prod = QP_W'(idx_q) * QP_W'(DIV_RECIP[DIV_SHIFT:0]);

  assign off = (state_q == F_MUL_RE) ? OFF_W'(col_q) - OFF_W'(WIDTH / 2)
                                     : OFF_W'(row_q) - OFF_W'(HEIGHT / 2);

  // The offset times the step is formed from two narrow partial products.
  assign plo = PART_W'(off) * PART_W'($signed({1'b0, pixel_step_i[STEP_SPLIT-1:0]}));
  assign phi = PART_W'(off) * PART_W'($signed({1'b0, pixel_step_i[STEP_W-1:STEP_SPLIT]}));

  assign prod    = PROD_W'(plo_q) + (PROD_W'(phi_q) <<< STEP_SPLIT);
  assign prod_ok = (&prod[PROD_W-1:DATA_W-1]) | ~(|prod[PROD_W-1:DATA_W-1]);

  assign center = (state_q == F_ADD_RE) ? center_x_i : center_y_i;
  assign sum    = {center[DATA_W-1], center} + {prod[DATA_W-1], prod[DATA_W-1:0]};
  assign add_ok = prod_ok && (sum[DATA_W] == sum[DATA_W-1]);

  always_comb begin
    state_d  = state_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_DIV;
        end
      end
      F_DIV:    state_d = F_COL;
      F_COL:    state_d = F_MUL_RE;
      F_MUL_RE: state_d = F_ADD_RE;
      F_ADD_RE: state_d = F_MUL_IM;
      F_MUL_IM: state_d = F_ADD_IM;
      F_ADD_IM: state_d = F_PUSH;
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default:  state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE:   idx_q <= pixel_index_i;
      F_DIV:    row_q <= quot_prod[DIV_SHIFT +: PIX_W];
      F_COL:    col_q <= idx_q - PIX_W'(row_q * WIDTH);
      F_MUL_RE, F_MUL_IM: begin
        plo_q <= plo;
        phi_q <= phi;
      end
      F_ADD_RE: begin
        c_q.re  <= sum[DATA_W-1:0];
        c_q.inf <= !add_ok;
      end
      F_ADD_IM: begin
        c_q.im  <= sum[DATA_W-1:0];
        c_q.inf <= c_q.inf | !add_ok;
      end
      default: ;
    endcase
  end

  assign full_o   = (state_q != F_IDLE);
  assign q_data_o = c_q;

endmodule

`default_nettype wire

// File: sv/mbe_queue.sv
// Two-entry queue of complex points between the front end and the iteration engine.
// Depends on mbe_pkg.
`default_nettype none

module mbe_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire mbe_pkg::cpoint_t data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output mbe_pkg::cpoint_t      data_o
);
  import mbe_pkg::*;

  cpoint_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/mbe_back.sv
// Iteration engine: runs z = z*z + c on a shared two-stage multiplier and
// holds the result register. Depends on mbe_pkg and mbe_mul.
`default_nettype none

module mbe_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_empty_i,
  input  wire mbe_pkg::cpoint_t                q_data_i,
  output logic                                 q_pop_o,
  input  wire logic        [mbe_pkg::CNT_W-1:0] max_iter_i,
  output logic                                 empty_o,
  input  wire logic                            pop_i,
  output logic             [mbe_pkg::CNT_W-1:0] iteration_count_o,
  output logic                                 escaped_o
);
  import mbe_pkg::*;

  function automatic logic [DATA_W:0] mul_post(logic [MAG_W-1:0] mag, logic neg,
                                                 logic half);
    logic [MAG_W-1:0]  q;
    logic              rem;
    logic              ok;
    logic [DATA_W-1:0] v;
    if (half) begin
      q   = mag >> (FRAC_BITS - 1);
      rem = |mag[FRAC_BITS-2:0];
    end else begin
      q   = mag >> FRAC_BITS;
      rem = |mag[FRAC_BITS-1:0];
    end
    q  = q + MAG_W'(neg && rem);
    ok = (q[MAG_W-1:DATA_W] == '0) &&
         (neg ? (q[DATA_W-1:0] <= {1'b1, {(DATA_W-1){1'b0}}}) : !q[DATA_W-1]);
    v  = neg ? (64'd0 - q[DATA_W-1:0]) : q[DATA_W-1:0];
    return {ok, v};
  endfunction

  back_state_e state_q, state_d;

  logic signed [DATA_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [DATA_W-1:0] sr_q, si_q, nr_q, t_q;
  logic                     inf_q, sr_ok_q, si_ok_q, nr_ok_q, t_ok_q, res_esc_q;
  logic        [CNT_W-1:0]  count_q;
  logic                     out_valid_q, out_esc_q;
  logic        [CNT_W-1:0]  out_count_q;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic        [MAG_W-1:0]  mag;
  logic                     neg;
  logic        [DATA_W:0]   post;
  logic        [DATA_W:0]   sq_sum;
  logic                     escape;
  logic signed [DATA_W-1:0] diff;
  logic        [DATA_W:0]   nr_sum, ni_sum;
  logic                     ni_ok;
  logic                     out_load, out_pop;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .mag_o (mag),
    .neg_o (neg)
  );

  always_comb begin
    case (state_q)
      B_TOP:      begin mul_a = zr_q; mul_b = zr_q; end
      B_ISSUE_II: begin mul_a = zi_q; mul_b = zi_q; end
      default:    begin mul_a = zr_q; mul_b = zi_q; end
    endcase
  end

  assign post   = mul_post(mag, neg, state_q == B_TEST);
  assign sq_sum = {1'b0, sr_q} + {1'b0, si_q};
  assign escape = !sr_ok_q || !si_ok_q || (sq_sum > ESC_LIMIT);
  assign diff   = sr_q - si_q;
  assign nr_sum = {diff[DATA_W-1], diff} + {cr_q[DATA_W-1], cr_q};
  assign ni_sum = {t_q[DATA_W-1], t_q} + {ci_q[DATA_W-1], ci_q};
  assign ni_ok  = (ni_sum[DATA_W] == ni_sum[DATA_W-1]);

  assign out_pop = pop_i && out_valid_q;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = B_TOP;
        end
      end
      B_TOP: begin
        if ((count_q == max_iter_i) || inf_q) begin
          state_d = B_DONE;
        end else begin
          state_d = B_ISSUE_II;
        end
      end
      B_ISSUE_II: state_d = B_ISSUE_RI;
      B_ISSUE_RI: state_d = B_GET_II;
      B_GET_II:   state_d = B_TEST;
      B_TEST:     state_d = escape ? B_DONE : B_UPDATE;
      B_UPDATE:   state_d = B_TOP;
      B_DONE: begin
        if (!out_valid_q || out_pop) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default:    state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cr_q    <= q_data_i.re;
        ci_q    <= q_data_i.im;
        inf_q   <= q_data_i.inf;
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end
      B_TOP: begin
        res_esc_q <= (count_q != max_iter_i);
      end
      B_ISSUE_RI: begin
        sr_q    <= post[DATA_W-1:0];
        sr_ok_q <= post[DATA_W];
      end
      B_GET_II: begin
        si_q    <= post[DATA_W-1:0];
        si_ok_q <= post[DATA_W];
      end
      B_TEST: begin
        res_esc_q <= 1'b1;
        count_q   <= count_q + CNT_W'(!escape);
        nr_q      <= nr_sum[DATA_W-1:0];
        nr_ok_q   <= (nr_sum[DATA_W] == nr_sum[DATA_W-1]);
        t_q       <= post[DATA_W-1:0];
        t_ok_q    <= post[DATA_W];
      end
      B_UPDATE: begin
        if (nr_ok_q && t_ok_q && ni_ok) begin
          zr_q <= nr_q;
          zi_q <= ni_sum[DATA_W-1:0];
        end else begin
          inf_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_count_q <= count_q;
      out_esc_q   <= res_esc_q;
    end
  end

  assign empty_o           = !out_valid_q;
  assign iteration_count_o = out_count_q;
  assign escaped_o         = out_esc_q;

endmodule

`default_nettype wire

// File: sv/mandelbrot_escape_time.sv
// Top level of the escape-time block: configuration registers, front end,
// point queue and iteration engine. Depends on mbe_pkg, mbe_front, mbe_queue, mbe_back.
//
// Input channel: a pixel index is taken on a rising edge with push_i high and
// full_o low. The front end holds one index at a time while it forms the point c,
// then hands it to a two-entry queue, so new indexes keep arriving while the engine
// is busy.
// Result channel: while empty_o is low, iteration_count_o and escaped_o hold
// the oldest result; a transaction completes on an edge with pop_i high.
// Each iteration sends the three products of a step through one two-stage 64x64
// multiplier and makes the checked adds after it. An item stops at the iteration
// limit, on an overflow, or when |z|^2 exceeds four; the engine takes the next
// point from the queue only once the last result is loaded.
// When the receiver stalls, the finished result stays in the output register,
// the engine holds its next result, and the queue and front end fill up
// before full_o stops further input.
// Reset clears all control state and loads the default view; configuration writes
// through cfg_we_i take effect at once, and the user must make them only while the block is idle (not enforced).
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [mbe_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  wire logic [mbe_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  wire logic                                 push_i,
  output logic                                      full_o,
  input  wire logic [mbe_pkg::PIX_W-1:0]            pixel_index_i,
  output logic                                      empty_o,
  input  wire logic                                 pop_i,
  output logic      [mbe_pkg::CNT_W-1:0]            iteration_count_o,
  output logic                                      escaped_o
);
  import mbe_pkg::*;

  logic signed [DATA_W-1:0] center_x_q, center_y_q;
  logic        [STEP_W-1:0] pixel_step_q;
  logic        [CNT_W-1:0]  max_iter_q;

  logic    q_push, q_full, q_pop, q_empty;
  cpoint_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      pixel_step_q <= 63'd14411518807585588;
      max_iter_q   <= 16'd200;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_CENTER_X:   center_x_q   <= cfg_wdata_i;
        CFG_CENTER_Y:   center_y_q   <= cfg_wdata_i;
        CFG_PIXEL_STEP: pixel_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_MAX_ITER:   max_iter_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .pixel_index_i (pixel_index_i),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .pixel_step_i  (pixel_step_q),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_data_o      (q_wdata)
  );

  mbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  mbe_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .max_iter_i        (max_iter_q),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the escape-time block: drives pixel transactions, predicts
// each iteration count and escaped flag in fixed point, and checks every result in order.
// Depends on mbe_pkg and mandelbrot_escape_time.
module testbench;
  import mbe_pkg::*;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             escaped;
  } escape_result_t;

  localparam q_t                 Q_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t                 Q_MIN         = 64'sh8000_0000_0000_0000;
  localparam logic signed [127:0] PROD_MAX     = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] PROD_MIN     = -PROD_MAX - 1;
  localparam q_t                 ESCAPE_LIMIT  = q_t'(4) <<< FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_DEFAULT  = 63'd14411518807585588;
  localparam logic [STEP_W-1:0]  STEP_MAX      = '1;
  localparam int                 CYCLE_LIMIT   = 4_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  cfg_reg_e             cfg_addr_i = CFG_CENTER_X;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 push_i = 1'b0;
  logic                 full_o;
  logic [PIX_W-1:0]     pixel_index_i = '0;
  logic                 empty_o;
  logic                 pop_i = 1'b0;
  logic [CNT_W-1:0]     iteration_count_o;
  logic                 escaped_o;

  q_t                   view_cx = '0;
  q_t                   view_cy = '0;
  logic [STEP_W-1:0]    view_step = STEP_DEFAULT;
  logic [CNT_W-1:0]     view_limit = 16'd200;

  escape_result_t       pending_results[$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   pop_stall_pct = 0;
  int                   hold_left = 0;

  mandelbrot_escape_time dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push_i            (push_i),
    .full_o            (full_o),
    .pixel_index_i     (pixel_index_i),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Exact product shifted right with rounding toward minus infinity; false on overflow.
  function automatic logic mul_fix(input q_t a, input q_t b, input int unsigned sh,
                                   output q_t r);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> sh;
    r = p[63:0];
    return (p <= PROD_MAX) && (p >= PROD_MIN);
  endfunction

  function automatic logic add_fix(input q_t a, input q_t b, output q_t r);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    r = s[63:0];
    return s[64] == s[63];
  endfunction

  function automatic escape_result_t predict_escape(input logic [PIX_W-1:0] idx);
    q_t             step_q, cr, ci, zr, zi, t, sr, si, mag, nr, ni;
    int             col, row;
    logic           inf;
    logic [CNT_W-1:0] count;
    escape_result_t res;
    step_q = {1'b0, view_step};
    col = int'(idx) % int'(WIDTH) - int'(WIDTH) / 2;
    row = int'(idx) / int'(WIDTH) - int'(HEIGHT) / 2;
    inf = 1'b0;
    cr = '0;
    ci = '0;
    if (!mul_fix(q_t'(col), step_q, 0, t) || !add_fix(view_cx, t, cr)) inf = 1'b1;
    if (!mul_fix(q_t'(row), step_q, 0, t) || !add_fix(view_cy, t, ci)) inf = 1'b1;
    zr = '0;
    zi = '0;
    count = '0;
    res.escaped = 1'b0;
    while (count < view_limit) begin
      if (inf || !mul_fix(zr, zr, FRAC_BITS, sr) || !mul_fix(zi, zi, FRAC_BITS, si) ||
          !add_fix(sr, si, mag) || mag > ESCAPE_LIMIT) begin
        res.escaped = 1'b1;
        break;
      end
      count++;
      if (!add_fix(sr - si, cr, nr) || !mul_fix(zr, zi, FRAC_BITS - 1, t) ||
          !add_fix(t, ci, ni)) begin
        inf = 1'b1;
      end else begin
        zr = nr;
        zi = ni;
      end
    end
    res.count = count;
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_at(input int col, input int row);
    return PIX_W'(row * int'(WIDTH) + col);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_result();
    escape_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result: count %0d escaped %0b",
                                iteration_count_o, escaped_o));
      return;
    end
    want = pending_results.pop_front();
    if (iteration_count_o !== want.count)
      report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                iteration_count_o, want.count));
    if (escaped_o !== want.escaped)
      report_mismatch($sformatf("escaped %0b, expected %0b (count %0d)",
                                escaped_o, want.escaped, want.count));
  endtask

  // Result side: a transaction completes on an edge with pop high and empty low.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) check_result();
    if (hold_left > 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push_i <= 1'b1;
    pixel_index_i <= idx;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    pending_results.push_back(predict_escape(idx));
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= which;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (which)
      CFG_CENTER_X:   view_cx = value;
      CFG_CENTER_Y:   view_cy = value;
      CFG_PIXEL_STEP: view_step = value[STEP_W-1:0];
      CFG_MAX_ITER:   view_limit = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input q_t cx, input q_t cy, input logic [STEP_W-1:0] step,
                          input logic [CNT_W-1:0] limit);
    wait_drained();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_PIXEL_STEP, {1'b0, step});
    write_reg(CFG_MAX_ITER, {{(DATA_W-CNT_W){1'b0}}, limit});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_view();
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(320, 240));
    send_pixel(pixel_at(160, 240));
    send_pixel(pixel_at(360, 240));
    send_pixel(pixel_at(320, 0));
    send_pixel(pixel_at(639, 479));
    send_pixel(PIX_W'(WIDTH * HEIGHT));
    send_pixel('1);
  endtask

  task automatic test_iteration_limits();
    set_view('0, '0, STEP_DEFAULT, 16'd0);
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(320, 240));
    set_view('0, '0, STEP_DEFAULT, 16'd1);
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(320, 240));
    set_view('0, '0, STEP_DEFAULT, 16'hFFFF);
    send_pixel(pixel_at(320, 240));
    send_pixel(pixel_at(0, 0));
  endtask

  task automatic test_overflow();
    set_view('0, '0, STEP_MAX, 16'd20);
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(321, 240));
    send_pixel(pixel_at(320, 241));
    send_pixel(pixel_at(320, 240));
    set_view(Q_MAX, Q_MIN, '0, 16'd20);
    send_pixel(pixel_at(320, 240));
    send_pixel(pixel_at(0, 0));
    set_view(Q_MAX, Q_MIN, 63'd1, 16'd20);
    send_pixel(pixel_at(321, 240));
    send_pixel(pixel_at(320, 239));
    send_pixel(pixel_at(319, 241));
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_view('0, '0, STEP_DEFAULT, 16'd8);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(negedge clk_i);
    hold_left = 400;
    @(posedge clk_i);
    repeat (12) send_pixel(PIX_W'($urandom_range(0, WIDTH * HEIGHT - 1)));
    wait_drained();
  endtask

  task automatic test_random_views();
    q_t               cx, cy;
    logic [STEP_W-1:0] step;
    logic [CNT_W-1:0]  limit;
    logic [PIX_W-1:0]  idx;
    int               k;
    for (int chunk = 0; chunk < 12; chunk++) begin
      if (chunk % 4 == 3) begin
        cx = {$urandom, $urandom};
        cy = {$urandom, $urandom};
        step = STEP_W'({$urandom, $urandom});
        limit = CNT_W'($urandom_range(1, 16));
      end else begin
        cx = q_t'(longint'($urandom_range(0, 3000)) - 64'sd2000) <<< 50;
        cy = q_t'(longint'($urandom_range(0, 2000)) - 64'sd1000) <<< 50;
        k = $urandom_range(36, 54);
        step = STEP_W'({$urandom, $urandom});
        step = (step & ((63'd1 << k) - 63'd1)) | (63'd1 << k);
        limit = CNT_W'($urandom_range(2, 48));
      end
      set_view(cx, cy, step, limit);
      case (chunk % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 49; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 49; end
        default: begin send_idle_pct = 29; pop_stall_pct = 29; end
      endcase
      repeat (125) begin
        if ($urandom_range(0, 99) < 85)
          idx = PIX_W'($urandom_range(0, WIDTH * HEIGHT - 1));
        else
          idx = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
        send_pixel(idx);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_iteration_limits();
    test_overflow();
    test_backpressure();
    test_random_views();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
